[hw/rtl/assert_macros.svh]
// Assertion macros shared by the tile running-max filter.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define TMF_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tmf: invariant violated");

// The consequent must hold in the same cycle as the antecedent.
`define TMF_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tmf: implication violated");

// The consequent must hold in the cycle after the antecedent.
`define TMF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tmf: next-cycle implication violated");

`endif

[hw/rtl/tmf_pkg.sv]
`default_nettype none

package tmf_pkg;

	// Payload and configuration widths.
	localparam int PIX_W     = 8;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	// Default size limits of the frame.
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_TILE_WIDTH   = 2'd2,
		REG_TILE_HEIGHT  = 2'd3
	} cfg_reg_t;

	// Register values after reset.
	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd480;
	localparam logic [CFG_W-1:0] TILE_WIDTH_RST   = 11'd8;
	localparam logic [CFG_W-1:0] TILE_HEIGHT_RST  = 11'd8;

endpackage

`default_nettype wire

[hw/rtl/tmf_if.sv]
`default_nettype none

// Input pixel channel.
interface tmf_pix_in_if;
	import tmf_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;
	logic             frame_start;

	modport source (output valid, output pixel_in, output frame_start, input ready);
	modport sink (input valid, input pixel_in, input frame_start, output ready);
endinterface

// Output pixel channel.
interface tmf_pix_out_if;
	import tmf_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             frame_end;

	modport source (output valid, output pixel_out, output frame_end, input ready);
	modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

// Configuration write channel.
interface tmf_cfg_if;
	import tmf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/tmf_ram.sv]
`default_nettype none

module tmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; the read data holds
	// until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/tile_running_max_filter.sv]
// Tile running-maximum filter for a raster-order stream of 8-bit gray pixels.
// Channels: pixels_in carries pixel_in and frame_start, pixels_out carries
// pixel_out and frame_end, both valid/ready. cfg writes image_width (0),
// image_height (1), tile_width (2) and tile_height (3); it is always ready
// and must be used only while the filter is idle.
// Every accepted pixel gives exactly one result pixel, in order.
// An accepted pixel is registered in the middle stage and then in the output register,
// from which it can be taken. Throughput: one pixel per clock while the receiver takes it.
// The running maximum of each tile column lives in a single-port-write,
// registered-read RAM; the read issued at acceptance and the write of the
// following stage set the two-stage pipeline, and a same-address write/read
// in one cycle is forwarded.
// Reset clears the position to the top-left corner and loads the default
// sizes (640 x 480, 8 x 8 tiles); the RAM needs no clearing, since an entry is
// always written by the first pixel of its tile before it is read.
// When the receiver stalls, the output register holds its pixel, the middle
// stage holds one more, and pixels_in.ready drops until the output is taken.
`default_nettype none

module tile_running_max_filter #(
	parameter int MAX_WIDTH  = tmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tmf_pkg::MAX_HEIGHT_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	tmf_pix_in_if.sink   pixels_in,
	tmf_pix_out_if.source pixels_out,
	tmf_cfg_if.sink      cfg
);
	import tmf_pkg::*;

`include "assert_macros.svh"

	// Widths: *W holds a size up to the limit, *A an index below it.
	localparam int XW  = $clog2(MAX_WIDTH + 1);
	localparam int XA  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT + 1);
	localparam int YA  = $clog2(MAX_HEIGHT);
	localparam int XCW = (XW > CFG_W) ? XW : CFG_W;
	localparam int YCW = (YW > CFG_W) ? YW : CFG_W;
	localparam int XS  = XW + 1;
	localparam int YS  = YW + 1;

	// Configuration registers.
	logic [CFG_W-1:0] img_w_q, img_h_q, tile_w_q, tile_h_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q  <= IMAGE_WIDTH_RST;
			img_h_q  <= IMAGE_HEIGHT_RST;
			tile_w_q <= TILE_WIDTH_RST;
			tile_h_q <= TILE_HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_IMAGE_WIDTH:  img_w_q  <= cfg.data;
				REG_IMAGE_HEIGHT: img_h_q  <= cfg.data;
				REG_TILE_WIDTH:   tile_w_q <= cfg.data;
				REG_TILE_HEIGHT:  tile_h_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Effective sizes: zero reads as one, larger values saturate at the limit.
	logic [XCW-1:0] w_ext, tw_ext;
	logic [YCW-1:0] h_ext, th_ext;
	logic [XW-1:0]  w_c, tw_c;
	logic [YW-1:0]  h_c, th_c;

	always_comb begin
		w_ext  = XCW'(img_w_q);
		tw_ext = XCW'(tile_w_q);
		h_ext  = YCW'(img_h_q);
		th_ext = YCW'(tile_h_q);
		if (w_ext == '0) w_ext = XCW'(1);
		else if (w_ext > XCW'(MAX_WIDTH)) w_ext = XCW'(MAX_WIDTH);
		if (tw_ext == '0) tw_ext = XCW'(1);
		else if (tw_ext > XCW'(MAX_WIDTH)) tw_ext = XCW'(MAX_WIDTH);
		if (h_ext == '0) h_ext = YCW'(1);
		else if (h_ext > YCW'(MAX_HEIGHT)) h_ext = YCW'(MAX_HEIGHT);
		if (th_ext == '0) th_ext = YCW'(1);
		else if (th_ext > YCW'(MAX_HEIGHT)) th_ext = YCW'(MAX_HEIGHT);
		w_c  = XW'(w_ext);
		tw_c = XW'(tw_ext);
		h_c  = YW'(h_ext);
		th_c = YW'(th_ext);
	end

	// Handshake control.
	logic valid_s1, out_valid_q, s1_adv, accept;

	assign s1_adv          = valid_s1 && (!out_valid_q || pixels_out.ready);
	assign pixels_in.ready = !valid_s1 || s1_adv;
	assign accept          = pixels_in.valid && pixels_in.ready;

	// Position of the next pixel.
	logic [XA-1:0] col_q, ox_q, tci_q;
	logic [YA-1:0] row_q, oy_q;

	// Position after a restart check for the current request.
	logic          restart;
	logic [XA-1:0] col_r, ox_r, tci_r;
	logic [YA-1:0] row_r, oy_r;

	always_comb begin
		restart = pixels_in.frame_start || (XW'(col_q) >= w_c) || (YW'(row_q) >= h_c) ||
			(XW'(ox_q) >= tw_c) || (YW'(oy_q) >= th_c);
		col_r = restart ? '0 : col_q;
		ox_r  = restart ? '0 : ox_q;
		tci_r = restart ? '0 : tci_q;
		row_r = restart ? '0 : row_q;
		oy_r  = restart ? '0 : oy_q;
	end

	// Tile classification and frame end for the current request.
	logic full0, first0, last0;

	always_comb begin
		full0 = ((XS'(col_r) - XS'(ox_r) + XS'(tw_c)) <= XS'(w_c)) &&
			((YS'(row_r) - YS'(oy_r) + YS'(th_c)) <= YS'(h_c));
		first0 = (ox_r == '0) && (oy_r == '0);
		last0  = (XW'(col_r) == (w_c - XW'(1))) && (YW'(row_r) == (h_c - YW'(1)));
	end

	// Position advance.
	logic [XW-1:0] col_inc, ox_inc;
	logic [YW-1:0] row_inc, oy_inc;
	logic [XA-1:0] col_n, ox_n, tci_n;
	logic [YA-1:0] row_n, oy_n;

	always_comb begin
		col_inc = XW'(col_r) + XW'(1);
		ox_inc  = XW'(ox_r) + XW'(1);
		row_inc = YW'(row_r) + YW'(1);
		oy_inc  = YW'(oy_r) + YW'(1);
		col_n   = col_inc[XA-1:0];
		ox_n    = ox_inc[XA-1:0];
		tci_n   = tci_r;
		row_n   = row_r;
		oy_n    = oy_r;
		if (ox_inc == tw_c) begin
			ox_n  = '0;
			tci_n = tci_r + XA'(1);
		end
		if (col_inc >= w_c) begin
			col_n = '0;
			ox_n  = '0;
			tci_n = '0;
			row_n = row_inc[YA-1:0];
			oy_n  = (oy_inc == th_c) ? '0 : oy_inc[YA-1:0];
			if (row_inc >= h_c) begin
				row_n = '0;
				oy_n  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			ox_q  <= '0;
			tci_q <= '0;
			row_q <= '0;
			oy_q  <= '0;
		end else if (accept) begin
			col_q <= col_n;
			ox_q  <= ox_n;
			tci_q <= tci_n;
			row_q <= row_n;
			oy_q  <= oy_n;
		end
	end

	// Stage 1 registers: the request waits here for the stored maximum.
	logic [PIX_W-1:0] pix_s1, fwd_data_s1;
	logic [XA-1:0]    idx_s1;
	logic             full_s1, first_s1, last_s1, fwd_hit_s1;

	// Read-modify-write of the tile maximum.
	logic             ram_we;
	logic [PIX_W-1:0] ram_rdata, stored_s1, result_s1;

	always_comb begin
		stored_s1 = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
		result_s1 = pix_s1;
		ram_we    = 1'b0;
		if (full_s1) begin
			if (first_s1 || (pix_s1 > stored_s1)) begin
				ram_we = s1_adv;
			end else begin
				result_s1 = stored_s1;
			end
		end
	end

	tmf_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_max_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_s1),
		.wdata(pix_s1),
		.re   (accept),
		.raddr(tci_r),
		.rdata(ram_rdata)
	);

	// Stage 1 valid and payload; a write to the entry read in the same cycle
	// is forwarded, since the RAM returns the old contents then.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pixels_in.pixel_in;
			idx_s1      <= tci_r;
			full_s1     <= full0;
			first_s1    <= first0;
			last_s1     <= last0;
			fwd_hit_s1  <= ram_we && (idx_s1 == tci_r);
			fwd_data_s1 <= pix_s1;
		end
	end

	// Output register.
	logic [PIX_W-1:0] pixel_out_q;
	logic             frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (pixels_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_out_q <= result_s1;
			frame_end_q <= last_s1;
		end
	end

	assign pixels_out.valid     = out_valid_q;
	assign pixels_out.pixel_out = pixel_out_q;
	assign pixels_out.frame_end = frame_end_q;

	// Assertions.
	`TMF_ASSERT_IMPL(a_stall_only_when_blocked, !pixels_in.ready,
		valid_s1 && out_valid_q && !pixels_out.ready)
	`TMF_ASSERT_IMPL(a_write_on_advance, ram_we, s1_adv && full_s1)
	`TMF_ASSERT_ALWAYS(a_offsets_within_row,
		(ox_q <= col_q) && (tci_q <= col_q) && (oy_q <= row_q))
	`TMF_ASSERT_NEXT(a_accept_fills_s1, accept, valid_s1)

endmodule

`default_nettype wire
